// ----- sv/rsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsa_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 16;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned KIND_W = 3;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned DEPTH_OUT_W = 5;

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH = 3'd0,
		KIND_ADD  = 3'd1,
		KIND_SUB  = 3'd2,
		KIND_MUL  = 3'd3,
		KIND_DIV  = 3'd4,
		KIND_SWAP = 3'd5
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_DIVZERO   = 3'd3,
		ST_EMPTY     = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_RHS,
		S_RD_LHS,
		S_LAT_LHS,
		S_EXEC,
		S_DIV,
		S_FIN,
		S_WR2,
		S_RD_TOP,
		S_LAT_TOP,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic       cap_in;      // latch kind/operand
		logic       rd_rhs;      // read address count-1
		logic       rd_lhs;      // read address count-2
		logic       rd_top;      // read address count-1 for top
		logic       lat_rhs;
		logic       lat_lhs;
		logic       lat_top;
		logic       clr_top;
		logic       exec;        // compute add/sub/mul, start div
		logic       div_step;
		logic       fin;         // resolve status, do first write / count update
		logic       wr2;         // second swap write
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic       is_push;
		logic       is_div;
		logic       is_bin;
		logic       is_swap;
		logic       full;
		logic       lt2;
		logic       empty_after;
		logic       div_done;
	} sts_t;

endpackage

// ----- sv/rsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsa_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/rsa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_div
// Restoring divider on magnitudes, one quotient bit per cycle while step is high.
// ----------------------------------------------------------------------------
module rsa_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          step,
	input  logic [rsa_pkg::DATA_W-1:0]    dividend,
	input  logic [rsa_pkg::DATA_W-1:0]    divisor,
	output logic [rsa_pkg::DATA_W-1:0]    quotient,
	output logic                          done
);

	localparam int unsigned W = rsa_pkg::DATA_W;

	logic [W-1:0]         quo_q;
	logic [W-1:0]         den_q;
	logic [W:0]           rem_q;
	logic [$clog2(W):0]   cnt_q;
	logic [W:0]           shifted;
	logic [W:0]           diff;

	assign shifted = {rem_q[W-1:0], quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(W)+1)'(W);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (step && cnt_q != '0) begin
			if (!diff[W]) begin
				rem_q <= diff;
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = (cnt_q == '0);

endmodule

// ----- sv/rsa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_dp
// Datapath: stack RAM, count, operand registers, ALU and divider.
// ----------------------------------------------------------------------------
module rsa_dp #(
	parameter int unsigned STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rsa_pkg::cmd_t                     cmd,
	output rsa_pkg::sts_t                     sts,
	input  logic [rsa_pkg::KIND_W-1:0]        kind,
	input  logic signed [rsa_pkg::DATA_W-1:0] operand,
	output logic [rsa_pkg::STATUS_W-1:0]      status_q,
	output logic signed [rsa_pkg::DATA_W-1:0] top_q,
	output logic [rsa_pkg::DEPTH_OUT_W-1:0]   depth_out
);

	localparam int unsigned W  = rsa_pkg::DATA_W;
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	logic [rsa_pkg::KIND_W-1:0] kind_q;
	logic signed [W-1:0]        opnd_q;
	logic signed [W-1:0]        rhs_q;
	logic signed [W-1:0]        lhs_q;
	logic signed [W+1:0]        sum_q;
	logic signed [2*W-1:0]      prod_q;
	logic                       neg_q;
	logic                       dz_q;
	logic [CW-1:0]              cnt_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [W-1:0]   wdata;
	logic [AW-1:0]  raddr;
	logic [W-1:0]   rdata;
	logic [W-1:0]   quo;
	logic           div_done;
	logic [W-1:0]   mag_l;
	logic [W-1:0]   mag_r;
	logic [CW-1:0]  cnt_m1;
	logic [CW-1:0]  cnt_m2;

	logic signed [2*W-1:0] res_wide;
	logic signed [W:0]     qs;
	rsa_pkg::status_t      st;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);

	assign mag_l = lhs_q[W-1] ? W'(-lhs_q) : lhs_q;
	assign mag_r = rhs_q[W-1] ? W'(-rhs_q) : rhs_q;

	rsa_ram #(.WIDTH(W), .DEPTH(STACK_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	rsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.exec),
		.step     (cmd.div_step),
		.dividend (mag_l),
		.divisor  (mag_r),
		.quotient (quo),
		.done     (div_done)
	);

	always_comb begin
		raddr = cnt_m1[AW-1:0];
		if (cmd.rd_lhs) begin
			raddr = cnt_m2[AW-1:0];
		end
	end

	always_comb begin
		qs = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
		res_wide = '0;
		case (rsa_pkg::kind_t'(kind_q))
			rsa_pkg::KIND_ADD,
			rsa_pkg::KIND_SUB: res_wide = (2*W)'(sum_q);
			rsa_pkg::KIND_MUL: res_wide = prod_q;
			default:           res_wide = (2*W)'(qs);
		endcase
		if (kind_q == rsa_pkg::KIND_DIV && dz_q) begin
			st = rsa_pkg::ST_DIVZERO;
		end else if (res_wide > (2*W)'(signed'({1'b0, {(W-1){1'b1}}}))) begin
			st = rsa_pkg::ST_OVERFLOW;
		end else if (res_wide < -(2*W)'(signed'({2'b01, {(W-1){1'b0}}}))) begin
			st = rsa_pkg::ST_UNDERFLOW;
		end else begin
			st = rsa_pkg::ST_OK;
		end
	end

	// write port
	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = opnd_q;
		if (cmd.fin) begin
			if (kind_q == rsa_pkg::KIND_PUSH) begin
				we = !sts.full;
			end else if (kind_q == rsa_pkg::KIND_SWAP) begin
				we    = !sts.lt2;
				waddr = cnt_m2[AW-1:0];
				wdata = rhs_q;
			end else if (sts.is_bin) begin
				we    = !sts.lt2 && st == rsa_pkg::ST_OK;
				waddr = cnt_m2[AW-1:0];
				wdata = res_wide[W-1:0];
			end
		end else if (cmd.wr2) begin
			we    = 1'b1;
			waddr = cnt_m1[AW-1:0];
			wdata = lhs_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			status_q <= rsa_pkg::ST_OK;
		end else if (cmd.fin) begin
			status_q <= rsa_pkg::ST_OK;
			if (sts.is_push) begin
				if (sts.full) begin
					status_q <= rsa_pkg::ST_FULL;
				end else begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (sts.is_bin || sts.is_swap) begin
				if (cnt_q == '0) begin
					status_q <= rsa_pkg::ST_EMPTY;
				end else if (sts.lt2) begin
					cnt_q    <= '0;
					status_q <= rsa_pkg::ST_EMPTY;
				end else if (sts.is_bin) begin
					status_q <= st;
					cnt_q    <= (st == rsa_pkg::ST_OK) ? cnt_m1 : cnt_m2;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			kind_q <= kind;
			opnd_q <= operand;
		end
		if (cmd.lat_rhs) begin
			rhs_q <= rdata;
		end
		if (cmd.lat_lhs) begin
			lhs_q <= rdata;
		end
		if (cmd.exec) begin
			if (kind_q == rsa_pkg::KIND_SUB) begin
				sum_q <= (W+2)'(lhs_q) - (W+2)'(rhs_q);
			end else begin
				sum_q <= (W+2)'(lhs_q) + (W+2)'(rhs_q);
			end
			prod_q <= lhs_q * rhs_q;
			neg_q  <= lhs_q[W-1] ^ rhs_q[W-1];
			dz_q   <= (rhs_q == '0);
		end
		if (cmd.clr_top) begin
			top_q <= '0;
		end else if (cmd.lat_top) begin
			top_q <= rdata;
		end
	end

	assign sts.is_push     = (kind_q == rsa_pkg::KIND_PUSH);
	assign sts.is_div      = (kind_q == rsa_pkg::KIND_DIV);
	assign sts.is_bin      = (kind_q == rsa_pkg::KIND_ADD) || (kind_q == rsa_pkg::KIND_SUB)
		|| (kind_q == rsa_pkg::KIND_MUL) || (kind_q == rsa_pkg::KIND_DIV);
	assign sts.is_swap     = (kind_q == rsa_pkg::KIND_SWAP);
	assign sts.full        = (cnt_q >= CW'(STACK_DEPTH));
	assign sts.lt2         = (cnt_q < CW'(2));
	assign sts.empty_after = (cnt_q == '0);
	assign sts.div_done    = div_done;

	assign depth_out = rsa_pkg::DEPTH_OUT_W'(cnt_q);

endmodule

// ----- sv/rsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsa_ctrl
// Controller: sequences reads, execution, writes and the result word.
// ----------------------------------------------------------------------------
module rsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output rsa_pkg::cmd_t cmd,
	input  rsa_pkg::sts_t sts
);

	rsa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			rsa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					state_d    = rsa_pkg::S_RD_RHS;
				end
			end
			rsa_pkg::S_RD_RHS: begin
				cmd.rd_rhs = 1'b1;
				if ((sts.is_bin || sts.is_swap) && !sts.lt2) begin
					state_d = rsa_pkg::S_RD_LHS;
				end else begin
					state_d = rsa_pkg::S_FIN;
				end
			end
			rsa_pkg::S_RD_LHS: begin
				cmd.rd_lhs  = 1'b1;
				cmd.lat_rhs = 1'b1;
				state_d     = rsa_pkg::S_LAT_LHS;
			end
			rsa_pkg::S_LAT_LHS: begin
				cmd.lat_lhs = 1'b1;
				state_d     = sts.is_swap ? rsa_pkg::S_FIN : rsa_pkg::S_EXEC;
			end
			rsa_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.is_div ? rsa_pkg::S_DIV : rsa_pkg::S_FIN;
			end
			rsa_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = rsa_pkg::S_FIN;
				end
			end
			rsa_pkg::S_FIN: begin
				cmd.fin = 1'b1;
				if (sts.is_swap && !sts.lt2) begin
					state_d = rsa_pkg::S_WR2;
				end else begin
					state_d = rsa_pkg::S_RD_TOP;
				end
			end
			rsa_pkg::S_WR2: begin
				cmd.wr2 = 1'b1;
				state_d = rsa_pkg::S_RD_TOP;
			end
			rsa_pkg::S_RD_TOP: begin
				cmd.rd_top = 1'b1;
				state_d    = rsa_pkg::S_LAT_TOP;
			end
			rsa_pkg::S_LAT_TOP: begin
				if (sts.empty_after) begin
					cmd.clr_top = 1'b1;
				end else begin
					cmd.lat_top = 1'b1;
				end
				state_d = rsa_pkg::S_OUT;
			end
			rsa_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = rsa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = rsa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/rpn_stack_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_alu
// 32-bit signed reverse-Polish stack calculator.
// ----------------------------------------------------------------------------
// One word in, one word out. A push, an unused kind, or an operation that
// finds fewer than two values skips the operand latches and execution;
// add, subtract and multiply latch two values and execute, swap latches two
// and writes twice, and divide runs the restoring divider at one quotient
// bit per cycle. The stack lives in a single-write, single-read RAM, so each
// operand read and each write takes its own state. One word is handled at a
// time; the next is accepted in the cycle after the result word is taken.
// ----------------------------------------------------------------------------
module rpn_stack_alu #(
	parameter int unsigned STACK_DEPTH = rsa_pkg::STACK_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rsa_pkg::KIND_W-1:0]          kind,
	input  logic signed [rsa_pkg::DATA_W-1:0]   operand,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rsa_pkg::STATUS_W-1:0]        status,
	output logic signed [rsa_pkg::DATA_W-1:0]   top_value,
	output logic [rsa_pkg::DEPTH_OUT_W-1:0]     depth
);

	rsa_pkg::cmd_t cmd;
	rsa_pkg::sts_t sts;

	rsa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	rsa_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.operand   (operand),
		.status_q  (status),
		.top_q     (top_value),
		.depth_out (depth)
	);

endmodule
